@@ rtl/dtfs_pkg.sv @@
package dtfs_pkg;

    localparam int CH_W       = 8;
    localparam int INT_W      = 31;
    localparam int FRAC_W     = 32;
    localparam int FACC_W     = 30;
    localparam int FCNT_W     = 4;
    localparam int SPAN_W     = 16;
    localparam int FRAC_DIGITS_DEF = 9;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CH_W-1:0] CH_DOT   = 8'd46;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;

    localparam logic [INT_W-1:0]  INT_MAX  = {INT_W{1'b1}};
    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WS,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        SQ_READY,
        SQ_EVAL,
        SQ_DIV,
        SQ_TOK,
        SQ_NONE
    } seq_state_t;

    typedef struct packed {
        logic                status;
        logic [INT_W-1:0]    int_part;
        logic [FRAC_W-1:0]   frac_part;
        logic [SPAN_W-1:0]   consumed;
        logic                last;
    } res_t;

    typedef struct packed {
        logic                start;
        logic [FACC_W-1:0]   num;
        logic [FCNT_W-1:0]   count;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [FRAC_W-1:0]   quot;
    } div_rsp_t;

    function automatic logic [FACC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
        logic [FACC_W-1:0] p;
        case (n)
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/dtfs_in_if.sv @@
interface dtfs_in_if;

    logic                          valid;
    logic                          ready;
    logic [dtfs_pkg::CH_W-1:0]     ch;
    logic                          first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);

endinterface

@@ rtl/dtfs_out_if.sv @@
interface dtfs_out_if;

    logic                          valid;
    logic                          ready;
    logic                          status;
    logic [dtfs_pkg::INT_W-1:0]    int_part;
    logic [dtfs_pkg::FRAC_W-1:0]   frac_part;
    logic [dtfs_pkg::SPAN_W-1:0]   consumed;
    logic                          last;

    modport source (output valid, output status, output int_part, output frac_part,
                    output consumed, output last, input ready);
    modport sink   (input valid, input status, input int_part, input frac_part,
                    input consumed, input last, output ready);

endinterface

@@ rtl/dtfs_div.sv @@
module dtfs_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  dtfs_pkg::div_req_t  req,
    output dtfs_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(dtfs_pkg::FRAC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dtfs_pkg::FRAC_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [dtfs_pkg::FACC_W-1:0]   rem_reg;
    logic [dtfs_pkg::FACC_W-1:0]   den_reg;
    logic [dtfs_pkg::FRAC_W-1:0]   quot_reg;

    logic [dtfs_pkg::FACC_W:0]     shifted;
    logic                          fits;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            den_reg  <= dtfs_pkg::pow10(req.count);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg  <= dtfs_pkg::FACC_W'(shifted - {1'b0, den_reg});
                quot_reg <= {quot_reg[dtfs_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[dtfs_pkg::FACC_W-1:0];
                quot_reg <= {quot_reg[dtfs_pkg::FRAC_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ rtl/dtfs_seq.sv @@
module dtfs_seq
#(
    parameter int FRAC_DIGITS = dtfs_pkg::FRAC_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    dtfs_in_if.sink             text,
    input  logic                out_free,
    output logic                res_wr,
    output dtfs_pkg::res_t      res,
    output dtfs_pkg::div_req_t  div_req,
    input  dtfs_pkg::div_rsp_t  div_rsp
);

    localparam logic [dtfs_pkg::FCNT_W-1:0] FCNT_LIM = dtfs_pkg::FCNT_W'(FRAC_DIGITS);

    dtfs_pkg::seq_state_t           state_reg, state_next;
    dtfs_pkg::phase_t               phase_reg, phase_next;
    logic [dtfs_pkg::INT_W-1:0]     int_acc_reg, int_acc_next;
    logic [dtfs_pkg::FACC_W-1:0]    frac_acc_reg, frac_acc_next;
    logic [dtfs_pkg::FCNT_W-1:0]    frac_count_reg, frac_count_next;
    logic [dtfs_pkg::SPAN_W-1:0]    span_reg, span_next;
    logic [dtfs_pkg::CH_W-1:0]      ch_reg;

    logic                           accept;
    logic                           is_ws, is_dig, is_dot;
    logic [3:0]                     digit;
    logic                           tok_c, none_c, halted;
    logic                           step_en, tok_wr, none_wr;
    logic [dtfs_pkg::INT_W+3:0]     int_mul;
    logic [dtfs_pkg::FACC_W+3:0]    frac_mul;
    logic [dtfs_pkg::SPAN_W:0]      span_sum;

    assign accept = text.valid && text.ready;

    // character classes of the held character
    always_comb
    begin
        is_ws  = (ch_reg == dtfs_pkg::CH_SPACE) ||
                 (ch_reg inside {[dtfs_pkg::CH_TAB:dtfs_pkg::CH_CR]});
        is_dig = ch_reg inside {[dtfs_pkg::CH_ZERO:dtfs_pkg::CH_NINE]};
        is_dot = ch_reg == dtfs_pkg::CH_DOT;
        digit  = 4'(ch_reg - dtfs_pkg::CH_ZERO);
    end

    // token end and no-number decisions for the current phase
    always_comb
    begin
        tok_c  = 1'b0;
        none_c = 1'b0;
        halted = 1'b0;
        case (phase_reg)
            dtfs_pkg::PH_IDLE: none_c = !is_ws && !is_dig && !is_dot;
            dtfs_pkg::PH_WS:   tok_c  = !is_ws && !is_dig && !is_dot;
            dtfs_pkg::PH_INT:  tok_c  = !is_dig && !is_dot;
            dtfs_pkg::PH_DOT:
            begin
                tok_c  = !is_dig && (span_reg != '0);
                none_c = !is_dig && (span_reg == '0);
            end
            dtfs_pkg::PH_FRAC: tok_c  = !is_dig;
            default:           halted = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtfs_pkg::SQ_READY:
            begin
                if (accept)
                    state_next = dtfs_pkg::SQ_EVAL;
            end
            dtfs_pkg::SQ_EVAL:
            begin
                if (halted)
                    state_next = dtfs_pkg::SQ_READY;
                else if (tok_c)
                    state_next = (frac_count_reg != '0) ? dtfs_pkg::SQ_DIV : dtfs_pkg::SQ_TOK;
                else if (none_c)
                    state_next = dtfs_pkg::SQ_NONE;
                else
                    state_next = dtfs_pkg::SQ_READY;
            end
            dtfs_pkg::SQ_DIV:
            begin
                if (div_rsp.done)
                    state_next = dtfs_pkg::SQ_TOK;
            end
            dtfs_pkg::SQ_TOK:
            begin
                if (out_free)
                    state_next = dtfs_pkg::SQ_EVAL;
            end
            dtfs_pkg::SQ_NONE:
            begin
                if (out_free)
                    state_next = dtfs_pkg::SQ_READY;
            end
            default: state_next = dtfs_pkg::SQ_READY;
        endcase
    end

    always_comb
    begin
        text.ready    = state_reg == dtfs_pkg::SQ_READY;
        step_en       = (state_reg == dtfs_pkg::SQ_EVAL) && !halted && !tok_c && !none_c;
        div_req.start = (state_reg == dtfs_pkg::SQ_EVAL) && tok_c && (frac_count_reg != '0);
        div_req.num   = frac_acc_reg;
        div_req.count = frac_count_reg;
        tok_wr        = (state_reg == dtfs_pkg::SQ_TOK) && out_free;
        none_wr       = (state_reg == dtfs_pkg::SQ_NONE) && out_free;
        res_wr        = tok_wr || none_wr;
        if (state_reg == dtfs_pkg::SQ_NONE)
        begin
            res.status    = 1'b1;
            res.int_part  = '0;
            res.frac_part = '0;
            res.consumed  = '0;
            res.last      = 1'b1;
        end
        else
        begin
            res.status    = 1'b0;
            res.int_part  = int_acc_reg;
            res.frac_part = (frac_count_reg != '0) ? div_rsp.quot : '0;
            res.consumed  = span_reg;
            // a second beat follows unless the character restarts a token
            res.last      = (phase_reg != dtfs_pkg::PH_DOT) && (is_ws || is_dot);
        end
    end

    // digit and length arithmetic
    always_comb
    begin
        int_mul  = ({4'b0, int_acc_reg} << 3) + ({4'b0, int_acc_reg} << 1) +
                   (dtfs_pkg::INT_W+4)'(digit);
        frac_mul = ({4'b0, frac_acc_reg} << 3) + ({4'b0, frac_acc_reg} << 1) +
                   (dtfs_pkg::FACC_W+4)'(digit);
        span_sum = {1'b0, span_reg} +
                   (dtfs_pkg::SPAN_W+1)'((phase_reg == dtfs_pkg::PH_DOT) ? 2 : 1);
    end

    always_comb
    begin
        phase_next      = phase_reg;
        int_acc_next    = int_acc_reg;
        frac_acc_next   = frac_acc_reg;
        frac_count_next = frac_count_reg;
        span_next       = span_reg;
        if (accept && text.first)
        begin
            phase_next      = dtfs_pkg::PH_IDLE;
            int_acc_next    = '0;
            frac_acc_next   = '0;
            frac_count_next = '0;
            span_next       = '0;
        end
        else if (step_en)
        begin
            if (is_dig)
            begin
                span_next = span_sum[dtfs_pkg::SPAN_W] ? dtfs_pkg::SPAN_MAX :
                            span_sum[dtfs_pkg::SPAN_W-1:0];
                if (phase_reg == dtfs_pkg::PH_DOT || phase_reg == dtfs_pkg::PH_FRAC)
                begin
                    phase_next = dtfs_pkg::PH_FRAC;
                    if (frac_count_reg < FCNT_LIM)
                    begin
                        frac_acc_next   = frac_mul[dtfs_pkg::FACC_W-1:0];
                        frac_count_next = frac_count_reg + 1'b1;
                    end
                end
                else
                begin
                    phase_next   = dtfs_pkg::PH_INT;
                    int_acc_next = (int_mul > {4'b0, dtfs_pkg::INT_MAX}) ? dtfs_pkg::INT_MAX :
                                   int_mul[dtfs_pkg::INT_W-1:0];
                end
            end
            else if (is_ws)
            begin
                phase_next = dtfs_pkg::PH_WS;
                span_next  = span_sum[dtfs_pkg::SPAN_W] ? dtfs_pkg::SPAN_MAX :
                             span_sum[dtfs_pkg::SPAN_W-1:0];
            end
            else
            begin
                phase_next = dtfs_pkg::PH_DOT;
            end
        end
        else if (tok_wr || none_wr)
        begin
            int_acc_next    = '0;
            frac_acc_next   = '0;
            frac_count_next = '0;
            span_next       = '0;
            // an empty dot token is left behind so the character gives no-number
            if (none_wr)
                phase_next = dtfs_pkg::PH_HALT;
            else if (phase_reg == dtfs_pkg::PH_DOT)
                phase_next = dtfs_pkg::PH_DOT;
            else
                phase_next = dtfs_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dtfs_pkg::SQ_READY;
            phase_reg      <= dtfs_pkg::PH_IDLE;
            int_acc_reg    <= '0;
            frac_acc_reg   <= '0;
            frac_count_reg <= '0;
            span_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            int_acc_reg    <= int_acc_next;
            frac_acc_reg   <= frac_acc_next;
            frac_count_reg <= frac_count_next;
            span_reg       <= span_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ch_reg <= text.ch;
    end

endmodule

@@ rtl/decimal_text_to_fixed_scanner.sv @@
// Scans text one character per beat and returns one result beat per numeric token:
// integer part saturated at 2^31-1, the fraction as Q0.32 truncated, and the token
// length including leading whitespace. A character that produces no result is
// accepted and then evaluated. A token ending with fraction digits then goes through
// the restoring divider: 32 quotient bits, one per cycle, then the finish flag. A token
// beat is written and then the character is evaluated again; a no-number beat is only
// written. Either beat may wait for the output register to free up. A no-number
// beat halts the scanner until a character marked first arrives.
module decimal_text_to_fixed_scanner
#(
    parameter int FRAC_DIGITS = dtfs_pkg::FRAC_DIGITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    dtfs_in_if.sink     text,
    dtfs_out_if.source  result
);

    dtfs_pkg::div_req_t div_req;
    dtfs_pkg::div_rsp_t div_rsp;
    dtfs_pkg::res_t     res;
    dtfs_pkg::res_t     res_reg;
    logic               res_wr;
    logic               out_valid_reg;
    logic               out_free;

    assign out_free = !out_valid_reg || result.ready;

    dtfs_seq #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .out_free (out_free),
        .res_wr   (res_wr),
        .res      (res),
        .div_req  (div_req),
        .div_rsp  (div_rsp)
    );

    dtfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_wr)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
            res_reg <= res;
    end

    assign result.valid     = out_valid_reg;
    assign result.status    = res_reg.status;
    assign result.int_part  = res_reg.int_part;
    assign result.frac_part = res_reg.frac_part;
    assign result.consumed  = res_reg.consumed;
    assign result.last      = res_reg.last;

    a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> out_free)
        else $error("result written over a pending beat");

    a_none_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status) |->
            (result.last && result.int_part == '0 && result.consumed == '0))
        else $error("no-number beat malformed");

    a_tok_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.status) |-> (result.consumed != '0))
        else $error("token beat with zero length");

    a_eval_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready) |=> !text.ready)
        else $error("character accepted before evaluation");

endmodule

@@ verif/decimal_text_to_fixed_scanner_tb.sv @@
`timescale 1ns / 1ps

module decimal_text_to_fixed_scanner_tb;

    localparam int FRAC_DIGITS   = dtfs_pkg::FRAC_DIGITS_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1380;
    localparam int QUIET_ITEMS   = 250;
    localparam int LONG_BLANKS   = 60;
    localparam int MAX_REPORTS   = 10;

    logic clk = 1'b0;
    logic rst_n;

    dtfs_in_if  text_if ();
    dtfs_out_if res_if ();

    decimal_text_to_fixed_scanner #(.FRAC_DIGITS(FRAC_DIGITS)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (res_if)
    );

    always #5 clk = ~clk;

    // scanner shadow state
    dtfs_pkg::phase_t            sc_ph;
    logic [dtfs_pkg::INT_W-1:0]  sc_int;
    logic [dtfs_pkg::FACC_W-1:0] sc_frac;
    logic [dtfs_pkg::FCNT_W-1:0] sc_cnt;
    logic [dtfs_pkg::SPAN_W-1:0] sc_span;

    dtfs_pkg::res_t char_results[$];
    dtfs_pkg::res_t pending_results[$];

    int   live_chars;
    int   token_beats;
    int   nonum_beats;
    int   err_cnt;
    int   cycle_cnt;
    int   hold_id;
    logic quiet;

    function automatic logic is_blank(logic [dtfs_pkg::CH_W-1:0] c);
        return c == dtfs_pkg::CH_SPACE || (c >= dtfs_pkg::CH_TAB && c <= dtfs_pkg::CH_CR);
    endfunction

    function automatic logic is_num(logic [dtfs_pkg::CH_W-1:0] c);
        return c >= dtfs_pkg::CH_ZERO && c <= dtfs_pkg::CH_NINE;
    endfunction

    function automatic void clear_acc();
        sc_int  = '0;
        sc_frac = '0;
        sc_cnt  = '0;
        sc_span = '0;
    endfunction

    function automatic void grow_span(int k);
        int s;
        s = int'(sc_span) + k;
        sc_span = (s > int'(dtfs_pkg::SPAN_MAX)) ? dtfs_pkg::SPAN_MAX : dtfs_pkg::SPAN_W'(s);
    endfunction

    function automatic void push_int_digit(logic [3:0] d);
        logic [35:0] v;
        v = 36'(sc_int) * 36'd10 + 36'(d);
        sc_int = (v > 36'(dtfs_pkg::INT_MAX)) ? dtfs_pkg::INT_MAX : dtfs_pkg::INT_W'(v);
    endfunction

    function automatic void push_frac_digit(logic [3:0] d);
        if (int'(sc_cnt) < FRAC_DIGITS)
        begin
            sc_frac = sc_frac * 30'd10 + dtfs_pkg::FACC_W'(d);
            sc_cnt  = sc_cnt + 1'b1;
        end
    endfunction

    function automatic void close_token(logic no_number);
        dtfs_pkg::res_t r;
        logic [63:0]    den;
        logic [63:0]    num;
        r.status    = no_number;
        r.int_part  = '0;
        r.frac_part = '0;
        r.consumed  = '0;
        r.last      = 1'b0;
        if (!no_number)
        begin
            r.int_part = sc_int;
            r.consumed = sc_span;
            if (sc_cnt != '0)
            begin
                den = 64'd1;
                for (int i = 0; i < int'(sc_cnt); i++)
                    den = den * 64'd10;
                num = {2'b00, sc_frac, 32'h0};
                r.frac_part = dtfs_pkg::FRAC_W'(num / den);
            end
        end
        char_results.push_back(r);
        clear_acc();
        sc_ph = no_number ? dtfs_pkg::PH_HALT : dtfs_pkg::PH_IDLE;
    endfunction

    function automatic void scan_char(logic [dtfs_pkg::CH_W-1:0] c, logic fresh);
        logic [3:0] d;
        logic       done;
        d    = 4'(c - dtfs_pkg::CH_ZERO);
        done = 1'b0;
        if (fresh)
        begin
            sc_ph = dtfs_pkg::PH_IDLE;
            clear_acc();
        end
        if (sc_ph == dtfs_pkg::PH_HALT)
            return;
        live_chars++;
        char_results.delete();
        while (!done)
        begin
            case (sc_ph)
                dtfs_pkg::PH_IDLE:
                begin
                    if (is_blank(c))
                    begin
                        sc_ph = dtfs_pkg::PH_WS;
                        grow_span(1);
                    end
                    else if (is_num(c))
                    begin
                        sc_ph = dtfs_pkg::PH_INT;
                        push_int_digit(d);
                        grow_span(1);
                    end
                    else if (c == dtfs_pkg::CH_DOT)
                        sc_ph = dtfs_pkg::PH_DOT;
                    else
                        close_token(1'b1);
                    done = 1'b1;
                end
                dtfs_pkg::PH_WS, dtfs_pkg::PH_INT:
                begin
                    if (sc_ph == dtfs_pkg::PH_WS && is_blank(c))
                    begin
                        grow_span(1);
                        done = 1'b1;
                    end
                    else if (is_num(c))
                    begin
                        sc_ph = dtfs_pkg::PH_INT;
                        push_int_digit(d);
                        grow_span(1);
                        done = 1'b1;
                    end
                    else if (c == dtfs_pkg::CH_DOT)
                    begin
                        sc_ph = dtfs_pkg::PH_DOT;
                        done  = 1'b1;
                    end
                    else
                        close_token(1'b0);
                end
                dtfs_pkg::PH_DOT:
                begin
                    if (is_num(c))
                    begin
                        sc_ph = dtfs_pkg::PH_FRAC;
                        push_frac_digit(d);
                        grow_span(2);
                    end
                    else
                    begin
                        if (sc_span != '0)
                            close_token(1'b0);
                        close_token(1'b1);
                    end
                    done = 1'b1;
                end
                dtfs_pkg::PH_FRAC:
                begin
                    if (is_num(c))
                    begin
                        push_frac_digit(d);
                        grow_span(1);
                        done = 1'b1;
                    end
                    else
                        close_token(1'b0);
                end
                default:
                begin
                    sc_ph = dtfs_pkg::PH_HALT;
                    done  = 1'b1;
                end
            endcase
        end
        if (char_results.size() > 0)
            char_results[char_results.size() - 1].last = 1'b1;
        foreach (char_results[i])
        begin
            if (char_results[i].status)
                nonum_beats++;
            else
                token_beats++;
            pending_results.push_back(char_results[i]);
        end
    endfunction

    function automatic void check_result();
        dtfs_pkg::res_t got;
        dtfs_pkg::res_t want;
        got.status    = res_if.status;
        got.int_part  = res_if.int_part;
        got.frac_part = res_if.frac_part;
        got.consumed  = res_if.consumed;
        got.last      = res_if.last;
        if (pending_results.size() == 0)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: unexpected result beat st=%0d int=%0d frac=%h len=%0d last=%0d",
                         $time, got.status, got.int_part, got.frac_part, got.consumed,
                         got.last);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status || got.int_part !== want.int_part ||
            got.frac_part !== want.frac_part || got.consumed !== want.consumed ||
            got.last !== want.last)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
            begin
                $display("%0t: result mismatch, expected st=%0d int=%0d frac=%h len=%0d last=%0d",
                         $time, want.status, want.int_part, want.frac_part, want.consumed,
                         want.last);
                $display("    got st=%0d int=%0d frac=%h len=%0d last=%0d",
                         got.status, got.int_part, got.frac_part, got.consumed, got.last);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_if.valid && text_if.ready)
                scan_char(text_if.ch, text_if.first);
            if (res_if.valid && res_if.ready)
                check_result();
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("decimal_text_to_fixed_scanner_tb: FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, plus a long hold whenever hold_id moves
    initial
    begin
        int stall_left;
        int hold_left;
        int seen_hold;
        stall_left   = 0;
        hold_left    = 0;
        seen_hold    = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_id != seen_hold)
            begin
                seen_hold = hold_id;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready = 1'b0;
            end
            else if (quiet)
                res_if.ready = 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left   = $urandom_range(0, 6);
                res_if.ready = 1'b0;
            end
            else
                res_if.ready = 1'b1;
        end
    end

    task automatic send_char(logic [dtfs_pkg::CH_W-1:0] c, logic fresh);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            text_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_if.valid = 1'b1;
        text_if.ch    = c;
        text_if.first = fresh;
        do
            @(posedge clk);
        while (!text_if.ready);
    endtask

    task automatic send_text(string s, logic fresh);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], fresh && i == 0);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        text_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [dtfs_pkg::CH_W-1:0] rand_blank();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? dtfs_pkg::CH_SPACE : dtfs_pkg::CH_W'(r);
    endfunction

    function automatic logic [dtfs_pkg::CH_W-1:0] rand_digit();
        return dtfs_pkg::CH_ZERO + dtfs_pkg::CH_W'($urandom_range(0, 9));
    endfunction

    task automatic test_directed();
        // vertical tab, saturating integer, fraction with leading zeros and dropped digits
        send_text("\0139999999999.0000000019 ", 1'b1);
        // blank-only token cut by a letter, then a character ignored while halted
        send_text("x", 1'b0);
        send_text("q", 1'b0);
        // fraction with no integer digits, then a bare dot cut by nul
        send_text(".5.", 1'b1);
        send_char(8'h00, 1'b0);
        // dot with no digit after an integer
        send_text("3.\377", 1'b1);
        wait_drain();
    endtask

    task automatic test_long_blank_token();
        quiet = 1'b1;
        send_char(dtfs_pkg::CH_SPACE, 1'b1);
        for (int i = 1; i < LONG_BLANKS; i++)
            send_char(dtfs_pkg::CH_SPACE, 1'b0);
        send_text("7,", 1'b0);
        wait_drain();
        quiet = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_id++;
        send_char(dtfs_pkg::CH_SPACE, 1'b1);
        for (int i = 0; i < 40; i++)
            send_text("12 ", 1'b0);
        send_text("4.25,", 1'b0);
        wait_drain();
    endtask

    task automatic send_random_text();
        logic [dtfs_pkg::CH_W-1:0] txt[$];
        logic [dtfs_pkg::CH_W-1:0] c;
        logic                      fresh;
        int                        ntok;
        int                        nws;
        int                        nint;
        int                        nfrac;
        int                        stop;
        fresh = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 8))
                txt.push_back(dtfs_pkg::CH_W'($urandom_range(0, 255)));
        end
        else
        begin
            ntok = $urandom_range(1, 4);
            for (int t = 0; t < ntok; t++)
            begin
                nws = (t == 0) ? $urandom_range(0, 2) : $urandom_range(1, 3);
                repeat (nws) txt.push_back(rand_blank());
                nint = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12)
                                                   : $urandom_range(0, 4);
                repeat (nint) txt.push_back(rand_digit());
                if ($urandom_range(0, 1) == 1)
                begin
                    txt.push_back(dtfs_pkg::CH_DOT);
                    nfrac = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12)
                                                        : $urandom_range(0, 4);
                    repeat (nfrac) txt.push_back(rand_digit());
                end
            end
            stop = $urandom_range(0, 3);
            if (stop == 2)
                txt.push_back(dtfs_pkg::CH_DOT);
            if (stop == 0)
                txt.push_back(8'h00);
            else if (stop != 3)
            begin
                do
                    c = dtfs_pkg::CH_W'($urandom_range(0, 255));
                while (is_blank(c) || is_num(c) || c == dtfs_pkg::CH_DOT);
                txt.push_back(c);
            end
        end
        foreach (txt[i])
            send_char(txt[i], fresh && i == 0);
    endtask

    task automatic test_random_text();
        int target;
        target = live_chars + RANDOM_ITEMS;
        while (live_chars < target)
        begin
            if (live_chars > target - QUIET_ITEMS)
                quiet = 1'b1;
            send_random_text();
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        quiet         = 1'b0;
        hold_id       = 0;
        live_chars    = 0;
        token_beats   = 0;
        nonum_beats   = 0;
        err_cnt       = 0;
        sc_ph         = dtfs_pkg::PH_IDLE;
        clear_acc();
        text_if.valid = 1'b0;
        text_if.ch    = '0;
        text_if.first = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_long_blank_token();
        test_output_hold();
        test_random_text();

        $display("scanned %0d characters into %0d token beats and %0d no-number beats",
                 live_chars, token_beats, nonum_beats);
        $display("run included a long blank token, a %0d-cycle output hold and random text",
                 HOLD_CYCLES);
        if (err_cnt == 0)
            $display("decimal_text_to_fixed_scanner_tb: PASS");
        else
            $display("decimal_text_to_fixed_scanner_tb: FAIL");
        $finish;
    end

endmodule
